/* rtl/core/assert_macros.svh */
// Assertion macros used by the core's top RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define ULLT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define ULLT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/ullt_pkg.sv */
// Types, codes and microprogram of the undoable linked-list table.
package ullt_pkg;

  // Fixed field widths of the word ports
  localparam int OP_W     = 3;
  localparam int STATUS_W = 3;
  localparam int INDEX_W  = 8;
  localparam int VERTEX_W = 16;

  // Sentinel entries
  localparam int HEAD_IDX = 0;
  localparam int TAIL_IDX = 1;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND,
    OP_LINK,
    OP_REMOVE,
    OP_RESTORE,
    OP_UNDO
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK,
    ST_BAD,
    ST_EMPTY,
    ST_FULL_TABLE,
    ST_FULL_STACK
  } status_e;

  // Check performed by a step; a failing check ends the item
  typedef enum logic [2:0] {
    CHK_NONE,
    CHK_TABLE,
    CHK_LINK,
    CHK_REMOVE,
    CHK_STACK,
    CHK_OPCODE
  } chk_e;

  // Source of the working entry id
  typedef enum logic [1:0] {
    ID_KEEP,
    ID_COUNT,
    ID_INDEX,
    ID_STACK
  } id_src_e;

  typedef enum logic [1:0] {
    NA_LAST,
    NA_ID,
    NA_PREV
  } next_addr_e;

  typedef enum logic [1:0] {
    ND_ID,
    ND_TAIL,
    ND_NEXT
  } next_data_e;

  typedef enum logic {
    PA_ID,
    PA_NEXT
  } prev_addr_e;

  typedef enum logic [1:0] {
    PD_LAST,
    PD_PREV,
    PD_ID
  } prev_data_e;

  typedef enum logic [1:0] {
    UD_CFG,
    UD_ONE,
    UD_ZERO
  } used_data_e;

  // Microprogram addresses
  localparam int UPC_W = 4;
  localparam logic [UPC_W-1:0] S_APP0 = 4'd0;
  localparam logic [UPC_W-1:0] S_APP1 = 4'd1;
  localparam logic [UPC_W-1:0] S_APP2 = 4'd2;
  localparam logic [UPC_W-1:0] S_LNK0 = 4'd3;
  localparam logic [UPC_W-1:0] S_LNK1 = 4'd4;
  localparam logic [UPC_W-1:0] S_LNK2 = 4'd5;
  localparam logic [UPC_W-1:0] S_REM0 = 4'd6;
  localparam logic [UPC_W-1:0] S_REM1 = 4'd7;
  localparam logic [UPC_W-1:0] S_RES0 = 4'd8;
  localparam logic [UPC_W-1:0] S_RES1 = 4'd9;
  localparam logic [UPC_W-1:0] S_RES2 = 4'd10;
  localparam logic [UPC_W-1:0] S_UND0 = 4'd11;
  localparam logic [UPC_W-1:0] S_UND1 = 4'd12;
  localparam logic [UPC_W-1:0] S_UND2 = 4'd13;
  localparam logic [UPC_W-1:0] S_BAD  = 4'd14;

  // One control word
  typedef struct packed {
    chk_e             chk;
    id_src_e          id_ld;
    logic             ent_rd;
    logic             stk_rd;
    logic             next_we;
    next_addr_e       na;
    next_data_e       nd;
    logic             prev_we;
    prev_addr_e       pa;
    prev_data_e       pd;
    logic             used_we;
    used_data_e       ud;
    logic             edge_we;
    logic             tail_we;
    logic             cnt_inc;
    logic             push;
    logic             pop;
    logic             done;
    logic [UPC_W-1:0] nxt;
  } ucw_t;

  // First step of each operation
  function automatic logic [UPC_W-1:0] dispatch(input logic [OP_W-1:0] op);
    logic [UPC_W-1:0] s;
    unique case (op)
      OP_APPEND:  s = S_APP0;
      OP_LINK:    s = S_LNK0;
      OP_REMOVE:  s = S_REM0;
      OP_RESTORE: s = S_RES0;
      OP_UNDO:    s = S_UND0;
      default:    s = S_BAD;
    endcase
    return s;
  endfunction

  // Control store
  function automatic ucw_t ucode_rom(input logic [UPC_W-1:0] upc);
    ucw_t w;
    w = '0;
    unique case (upc)
      // append: claim slot, store edge and link before tail, close link
      S_APP0: begin
        w.chk   = CHK_TABLE;
        w.id_ld = ID_COUNT;
        w.nxt   = S_APP1;
      end
      S_APP1: begin
        w.edge_we = 1'b1;
        w.used_we = 1'b1;
        w.ud      = UD_CFG;
        w.prev_we = 1'b1;
        w.pa      = PA_ID;
        w.pd      = PD_LAST;
        w.next_we = 1'b1;
        w.na      = NA_LAST;
        w.nd      = ND_ID;
        w.nxt     = S_APP2;
      end
      S_APP2: begin
        w.next_we = 1'b1;
        w.na      = NA_ID;
        w.nd      = ND_TAIL;
        w.tail_we = 1'b1;
        w.cnt_inc = 1'b1;
        w.done    = 1'b1;
      end
      // link: fetch entry, check and link before tail
      S_LNK0: begin
        w.id_ld  = ID_INDEX;
        w.ent_rd = 1'b1;
        w.nxt    = S_LNK1;
      end
      S_LNK1: begin
        w.chk     = CHK_LINK;
        w.used_we = 1'b1;
        w.ud      = UD_ONE;
        w.push    = 1'b1;
        w.next_we = 1'b1;
        w.na      = NA_LAST;
        w.nd      = ND_ID;
        w.prev_we = 1'b1;
        w.pa      = PA_ID;
        w.pd      = PD_LAST;
        w.nxt     = S_LNK2;
      end
      S_LNK2: begin
        w.next_we = 1'b1;
        w.na      = NA_ID;
        w.nd      = ND_TAIL;
        w.tail_we = 1'b1;
        w.done    = 1'b1;
      end
      // remove: fetch entry, check and unlink
      S_REM0: begin
        w.id_ld  = ID_INDEX;
        w.ent_rd = 1'b1;
        w.nxt    = S_REM1;
      end
      S_REM1: begin
        w.chk     = CHK_REMOVE;
        w.next_we = 1'b1;
        w.na      = NA_PREV;
        w.nd      = ND_NEXT;
        w.prev_we = 1'b1;
        w.pa      = PA_NEXT;
        w.pd      = PD_PREV;
        w.used_we = 1'b1;
        w.ud      = UD_ZERO;
        w.push    = 1'b1;
        w.done    = 1'b1;
      end
      // restore: pop removed stack, fetch entry, splice back
      S_RES0: begin
        w.chk    = CHK_STACK;
        w.stk_rd = 1'b1;
        w.nxt    = S_RES1;
      end
      S_RES1: begin
        w.id_ld  = ID_STACK;
        w.ent_rd = 1'b1;
        w.nxt    = S_RES2;
      end
      S_RES2: begin
        w.prev_we = 1'b1;
        w.pa      = PA_NEXT;
        w.pd      = PD_ID;
        w.next_we = 1'b1;
        w.na      = NA_PREV;
        w.nd      = ND_ID;
        w.used_we = 1'b1;
        w.ud      = UD_ONE;
        w.pop     = 1'b1;
        w.done    = 1'b1;
      end
      // undo: pop add stack, fetch entry, unlink
      S_UND0: begin
        w.chk    = CHK_STACK;
        w.stk_rd = 1'b1;
        w.nxt    = S_UND1;
      end
      S_UND1: begin
        w.id_ld  = ID_STACK;
        w.ent_rd = 1'b1;
        w.nxt    = S_UND2;
      end
      S_UND2: begin
        w.next_we = 1'b1;
        w.na      = NA_PREV;
        w.nd      = ND_NEXT;
        w.prev_we = 1'b1;
        w.pa      = PA_NEXT;
        w.pd      = PD_PREV;
        w.used_we = 1'b1;
        w.ud      = UD_ZERO;
        w.pop     = 1'b1;
        w.done    = 1'b1;
      end
      // unknown operation code, and unused addresses
      default: begin
        w.chk  = CHK_OPCODE;
        w.done = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

/* rtl/core/ullt_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module ullt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/ullt_useq.sv */
// Microcode sequencer: step counter, dispatch and control store lookup.
module ullt_useq (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [ullt_pkg::OP_W-1:0] start_op_i,
  input  logic                      step_en_i,
  input  logic                      finish_i,
  output logic                      busy_o,
  output ullt_pkg::ucw_t            ucw_o
);

  import ullt_pkg::*;

  logic [UPC_W-1:0] upc_q, upc_d;
  logic             busy_q, busy_d;
  ucw_t             ucw;

  assign ucw = ucode_rom(upc_q);

  // Dispatch on a new word, advance on each executed step, drop busy at the end
  always_comb begin
    upc_d  = upc_q;
    busy_d = busy_q;
    if (start_i) begin
      upc_d  = dispatch(start_op_i);
      busy_d = 1'b1;
    end else if (finish_i) begin
      busy_d = 1'b0;
    end else if (step_en_i) begin
      upc_d = ucw.nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q  <= S_APP0;
      busy_q <= 1'b0;
    end else begin
      upc_q  <= upc_d;
      busy_q <= busy_d;
    end
  end

  assign busy_o = busy_q;
  assign ucw_o  = ucw;

endmodule

/* rtl/core/undoable_linked_list_table_core.sv */
// Control steps per word: append 3, link 3, remove 2, restore 3, undo 3, error 1-2.
// The result is registered at the last step, and steps wait while an untaken result is held; the
// next word is taken in the last step's cycle. Registered RAM reads and write ports set the steps.
// Reset clears the sequencer, stack tops and tail link and sets the entry count past the sentinels;
// the RAMs are not cleared and no entry is read before it is written, so words are taken right after reset.
`include "assert_macros.svh"

module undoable_linked_list_table_core #(
  parameter int TABLE_DEPTH = 256,
  parameter int STACK_DEPTH = 256,
  parameter int VERTEX_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [ullt_pkg::OP_W-1:0]     operation_i,
  input  logic [ullt_pkg::INDEX_W-1:0]  entry_index_i,
  input  logic [ullt_pkg::VERTEX_W-1:0] from_vertex_i,
  input  logic [ullt_pkg::VERTEX_W-1:0] to_vertex_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [ullt_pkg::STATUS_W-1:0] status_o,
  output logic [ullt_pkg::INDEX_W-1:0]  affected_index_o,
  output logic [ullt_pkg::VERTEX_W-1:0] edge_from_o,
  output logic [ullt_pkg::VERTEX_W-1:0] edge_to_o
);

  import ullt_pkg::*;

  localparam int IdxW = $clog2(TABLE_DEPTH);
  localparam int CntW = $clog2(TABLE_DEPTH + 1);
  localparam int SpW  = $clog2(STACK_DEPTH);
  localparam int TopW = $clog2(STACK_DEPTH + 1);
  localparam int VsW  = (VERTEX_BITS < VERTEX_W) ? VERTEX_BITS : VERTEX_W;
  localparam int CmpW = (CntW > INDEX_W) ? CntW : INDEX_W;
  localparam int AffW = (IdxW > INDEX_W) ? IdxW : INDEX_W;
  localparam logic [IdxW-1:0] TailId = IdxW'(TAIL_IDX);
  localparam logic [IdxW-1:0] HeadId = IdxW'(HEAD_IDX);

  // Sequencer handshake
  ucw_t ucw;
  logic busy;
  logic accept, out_free, step_en, exec, finish;

  // Input word and working registers
  logic [OP_W-1:0]     op_q;
  logic [INDEX_W-1:0]  idx_q;
  logic [VsW-1:0]      from_q, to_q;
  logic [IdxW-1:0]     id_q, id_d;
  logic [CntW-1:0]     cnt_q;
  logic [TopW-1:0]     rtop_q, atop_q;
  logic [IdxW-1:0]     tail_prev_q, tail_prev_d;
  logic                new_used_q;

  // Result register
  logic                out_valid_q;
  logic [STATUS_W-1:0] status_q;
  logic [INDEX_W-1:0]  aff_q;
  logic [VERTEX_W-1:0] efrom_q, eto_q;

  // RAM ports
  logic                ent_re;
  logic [IdxW-1:0]     next_rd, prev_rd, stk_rd, rstk_rd, astk_rd;
  logic [0:0]          used_rd;
  logic [2*VsW-1:0]    edge_rd;
  logic                next_we, prev_we, used_we, edge_we;
  logic [IdxW-1:0]     next_waddr, next_wdata, prev_waddr, prev_wdata;
  logic [0:0]          used_wdata;

  // Stack selection
  logic                use_add;
  logic [TopW-1:0]     top_sel, top_m1;
  logic                stk_re, stk_we;

  // Checks
  logic [CmpW-1:0]     idx_ext;
  logic                idx_ok;
  logic                chk_fail;
  status_e             chk_status;
  logic [AffW-1:0]     id_ext;
  logic [VsW-1:0]      res_from, res_to;

  ullt_useq u_useq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .start_op_i (operation_i),
    .step_en_i  (step_en),
    .finish_i   (finish),
    .busy_o     (busy),
    .ucw_o      (ucw)
  );

  // Step only when the result register can take a word
  assign out_free   = !out_valid_q || !out_stall_i;
  assign step_en    = busy && out_free;
  assign exec       = step_en && !chk_fail;
  assign finish     = step_en && (ucw.done || chk_fail);
  assign in_stall_o = busy && !finish;
  assign accept     = in_valid_i && !in_stall_o;

  // Latch the input word
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= operation_i;
      idx_q  <= entry_index_i;
      from_q <= from_vertex_i[VsW-1:0];
      to_q   <= to_vertex_i[VsW-1:0];
    end
  end

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      new_used_q <= 1'b1;
    end else if (cfg_we_i) begin
      new_used_q <= cfg_wdata_i;
    end
  end

  // Pick the stack: link and undo use the add stack, remove and restore the removed stack
  assign use_add = (op_q == OP_LINK) || (op_q == OP_UNDO);
  assign top_sel = use_add ? atop_q : rtop_q;
  assign top_m1  = top_sel - TopW'(1);
  assign stk_rd  = use_add ? astk_rd : rstk_rd;
  assign stk_re  = step_en && ucw.stk_rd;
  assign stk_we  = exec && ucw.push;

  // Working entry id
  assign idx_ext = CmpW'(idx_q);
  always_comb begin
    unique case (ucw.id_ld)
      ID_COUNT: id_d = cnt_q[IdxW-1:0];
      ID_INDEX: id_d = idx_ext[IdxW-1:0];
      ID_STACK: id_d = stk_rd;
      default:  id_d = id_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (step_en) begin
      id_q <= id_d;
    end
  end

  assign ent_re = step_en && ucw.ent_rd;

  // Checks on the addressed entry and the counters
  assign idx_ok = (idx_q != INDEX_W'(HEAD_IDX)) && (idx_q != INDEX_W'(TAIL_IDX)) &&
                  (idx_ext < CmpW'(cnt_q));

  always_comb begin
    chk_fail   = 1'b0;
    chk_status = ST_OK;
    unique case (ucw.chk)
      CHK_NONE: begin
        chk_fail = 1'b0;
      end
      CHK_TABLE: begin
        if (cnt_q == CntW'(TABLE_DEPTH)) begin
          chk_fail   = 1'b1;
          chk_status = ST_FULL_TABLE;
        end
      end
      CHK_LINK: begin
        if (!idx_ok || used_rd[0]) begin
          chk_fail   = 1'b1;
          chk_status = ST_BAD;
        end else if (atop_q == TopW'(STACK_DEPTH)) begin
          chk_fail   = 1'b1;
          chk_status = ST_FULL_STACK;
        end
      end
      CHK_REMOVE: begin
        if (!idx_ok || !used_rd[0]) begin
          chk_fail   = 1'b1;
          chk_status = ST_BAD;
        end else if (rtop_q == TopW'(STACK_DEPTH)) begin
          chk_fail   = 1'b1;
          chk_status = ST_FULL_STACK;
        end
      end
      CHK_STACK: begin
        if (top_sel == '0) begin
          chk_fail   = 1'b1;
          chk_status = ST_EMPTY;
        end
      end
      CHK_OPCODE: begin
        chk_fail   = 1'b1;
        chk_status = ST_BAD;
      end
      default: begin
        chk_fail   = 1'b1;
        chk_status = ST_BAD;
      end
    endcase
  end

  // Next-link write port
  assign next_we = exec && ucw.next_we;
  always_comb begin
    unique case (ucw.na)
      NA_LAST: next_waddr = tail_prev_q;
      NA_ID:   next_waddr = id_q;
      NA_PREV: next_waddr = prev_rd;
      default: next_waddr = id_q;
    endcase
    unique case (ucw.nd)
      ND_ID:   next_wdata = id_q;
      ND_TAIL: next_wdata = TailId;
      ND_NEXT: next_wdata = next_rd;
      default: next_wdata = id_q;
    endcase
  end

  // Prev-link write port
  assign prev_we = exec && ucw.prev_we;
  always_comb begin
    unique case (ucw.pa)
      PA_ID:   prev_waddr = id_q;
      PA_NEXT: prev_waddr = next_rd;
      default: prev_waddr = id_q;
    endcase
    unique case (ucw.pd)
      PD_LAST: prev_wdata = tail_prev_q;
      PD_PREV: prev_wdata = prev_rd;
      PD_ID:   prev_wdata = id_q;
      default: prev_wdata = id_q;
    endcase
  end

  // Used flag write port
  assign used_we = exec && ucw.used_we;
  always_comb begin
    unique case (ucw.ud)
      UD_CFG:  used_wdata = new_used_q;
      UD_ONE:  used_wdata = 1'b1;
      UD_ZERO: used_wdata = 1'b0;
      default: used_wdata = 1'b0;
    endcase
  end

  assign edge_we = exec && ucw.edge_we;

  // Shadow the tail's prev link in a register; it is the only link read without a write first
  always_comb begin
    tail_prev_d = tail_prev_q;
    if (exec && ucw.tail_we) begin
      tail_prev_d = id_q;
    end else if (prev_we && (prev_waddr == TailId)) begin
      tail_prev_d = prev_wdata;
    end
  end

  // Counters and tail link
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= CntW'(TAIL_IDX + 1);
      rtop_q      <= '0;
      atop_q      <= '0;
      tail_prev_q <= HeadId;
    end else begin
      tail_prev_q <= tail_prev_d;
      if (exec && ucw.cnt_inc) begin
        cnt_q <= cnt_q + CntW'(1);
      end
      if (exec && (ucw.push || ucw.pop)) begin
        if (use_add) begin
          atop_q <= ucw.push ? atop_q + TopW'(1) : atop_q - TopW'(1);
        end else begin
          rtop_q <= ucw.push ? rtop_q + TopW'(1) : rtop_q - TopW'(1);
        end
      end
    end
  end

  ullt_ram #(.WIDTH(IdxW), .DEPTH(TABLE_DEPTH)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (next_we),
    .waddr_i (next_waddr),
    .wdata_i (next_wdata),
    .re_i    (ent_re),
    .raddr_i (id_d),
    .rdata_o (next_rd)
  );

  ullt_ram #(.WIDTH(IdxW), .DEPTH(TABLE_DEPTH)) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (prev_we),
    .waddr_i (prev_waddr),
    .wdata_i (prev_wdata),
    .re_i    (ent_re),
    .raddr_i (id_d),
    .rdata_o (prev_rd)
  );

  ullt_ram #(.WIDTH(1), .DEPTH(TABLE_DEPTH)) u_used_ram (
    .clk_i   (clk_i),
    .we_i    (used_we),
    .waddr_i (id_q),
    .wdata_i (used_wdata),
    .re_i    (ent_re),
    .raddr_i (id_d),
    .rdata_o (used_rd)
  );

  ullt_ram #(.WIDTH(2 * VsW), .DEPTH(TABLE_DEPTH)) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (edge_we),
    .waddr_i (id_q),
    .wdata_i ({from_q, to_q}),
    .re_i    (ent_re),
    .raddr_i (id_d),
    .rdata_o (edge_rd)
  );

  ullt_ram #(.WIDTH(IdxW), .DEPTH(STACK_DEPTH)) u_rstk_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we && !use_add),
    .waddr_i (top_sel[SpW-1:0]),
    .wdata_i (id_q),
    .re_i    (stk_re && !use_add),
    .raddr_i (top_m1[SpW-1:0]),
    .rdata_o (rstk_rd)
  );

  ullt_ram #(.WIDTH(IdxW), .DEPTH(STACK_DEPTH)) u_astk_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we && use_add),
    .waddr_i (top_sel[SpW-1:0]),
    .wdata_i (id_q),
    .re_i    (stk_re && use_add),
    .raddr_i (top_m1[SpW-1:0]),
    .rdata_o (astk_rd)
  );

  // Result fields: append reports its own input edge, the others the stored edge
  assign id_ext   = AffW'(id_q);
  assign res_from = (op_q == OP_APPEND) ? from_q : edge_rd[2*VsW-1:VsW];
  assign res_to   = (op_q == OP_APPEND) ? to_q : edge_rd[VsW-1:0];

  always_ff @(posedge clk_i) begin
    if (finish) begin
      if (chk_fail) begin
        status_q <= chk_status;
        aff_q    <= '0;
        efrom_q  <= '0;
        eto_q    <= '0;
      end else begin
        status_q <= ST_OK;
        aff_q    <= id_ext[INDEX_W-1:0];
        efrom_q  <= VERTEX_W'(res_from);
        eto_q    <= VERTEX_W'(res_to);
      end
    end
  end

  // Hold the result word until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign affected_index_o = aff_q;
  assign edge_from_o      = efrom_q;
  assign edge_to_o        = eto_q;

  // Microcode never pushes a full stack or pops an empty one
  `ULLT_ASSERT_IMP(a_push_room, exec && ucw.push, top_sel != TopW'(STACK_DEPTH), "push on full stack")
  `ULLT_ASSERT_IMP(a_pop_data, exec && ucw.pop, top_sel != '0, "pop on empty stack")
  // A good append leaves the new entry as last before the tail
  `ULLT_ASSERT_NXT(a_tail_append, finish && !chk_fail && (op_q == OP_APPEND), tail_prev_q == $past(id_q), "tail link not updated")
  // Every finished word shows up at the output
  `ULLT_ASSERT_NXT(a_result_out, finish, out_valid_q, "result word lost")

endmodule
